@@ rtl/life_cell_next_state_top_macros.svh @@
// Assertion macros shared by the Life cell next-state RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef LIFE_CELL_NEXT_STATE_TOP_MACROS_SVH
`define LIFE_CELL_NEXT_STATE_TOP_MACROS_SVH

// Same-cycle implication, muted during reset.
`define LCNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted during reset.
`define LCNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lcns_pkg.sv @@
// Package for the Life cell next-state block: widths, codes, command/status types.
// No dependencies.
`timescale 1ns / 1ps

package lcns_pkg;

    localparam int GRID_ROWS_DEF = 128;
    localparam int GRID_COLS_DEF = 128;

    localparam int ROW_W   = 7;
    localparam int COL_W   = 7;
    localparam int FIRST_W = 7;
    localparam int END_W   = 8;

    localparam logic [FIRST_W-1:0] FIRST_RST = 7'd0;
    localparam logic [END_W-1:0]   END_RST   = 8'd128;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register select is byte address bit 2
    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_END   = 1'b1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CENTER = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_MAX     = 4'd8;
    localparam logic [CNT_W-1:0] CNT_BIRTH   = 4'd3;
    localparam logic [CNT_W-1:0] CNT_SURVIVE = 4'd2;

    typedef struct packed {
        logic              load;
        logic              clear;
        logic              addr;
        logic              read;
        logic              write;
        logic              emit;
        logic              oob;
        logic [STEP_W-1:0] step;
    } lcns_cmd_t;

    typedef struct packed {
        logic query;
        logic oob;
        logic write_ok;
        logic busy;
        logic out_free;
    } lcns_status_t;

endpackage

@@ rtl/lcns_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lcns_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lcns_datapath.sv @@
// Datapath: request registers, neighbor addressing, grid RAM, count and result register.
// Depends on lcns_pkg, lcns_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "life_cell_next_state_top_macros.svh"

module lcns_datapath #(
    parameter int GRID_ROWS = lcns_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lcns_pkg::GRID_COLS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lcns_pkg::lcns_cmd_t         cmd,
    output lcns_pkg::lcns_status_t      status,
    input  logic                        s_mode,
    input  logic [lcns_pkg::ROW_W-1:0]  s_row,
    input  logic [lcns_pkg::COL_W-1:0]  s_col,
    input  logic                        s_cell_value,
    input  logic [lcns_pkg::FIRST_W-1:0] band_first_row,
    input  logic [lcns_pkg::END_W-1:0]  band_end_row,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_next_state,
    output logic                        m_out_of_band
);

    localparam int RW_G  = $clog2(GRID_ROWS + 1);
    localparam int CW_G  = $clog2(GRID_COLS + 1);
    localparam int RW    = (RW_G > lcns_pkg::ROW_W) ? RW_G : lcns_pkg::ROW_W;
    localparam int CW    = (CW_G > lcns_pkg::COL_W) ? CW_G : lcns_pkg::COL_W;
    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic                        mode_reg;
    logic [lcns_pkg::ROW_W-1:0]  row_reg;
    logic [lcns_pkg::COL_W-1:0]  col_reg;
    logic                        value_reg;

    logic [AW-1:0]               addr_reg;
    logic                        addr_vld_reg;
    logic                        addr_self_reg;
    logic                        rd_vld_reg;
    logic                        rd_self_reg;
    logic [lcns_pkg::CNT_W-1:0]  count_reg;
    logic                        self_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_state_reg;
    logic                        out_oob_reg;

    logic [RW-1:0]               row_x;
    logic [RW-1:0]               row_prev;
    logic [RW-1:0]               row_next;
    logic [RW-1:0]               row_sel;
    logic [CW-1:0]               col_x;
    logic [CW-1:0]               col_prev;
    logic [CW-1:0]               col_next;
    logic [CW-1:0]               col_sel;
    logic [AW-1:0]               addr_calc;
    logic                        in_grid;
    logic                        in_band;
    logic                        life_bit;
    logic                        ram_rdata;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= s_mode;
            row_reg   <= s_row;
            col_reg   <= s_col;
            value_reg <= s_cell_value;
        end
    end

    assign row_x    = RW'(row_reg);
    assign col_x    = CW'(col_reg);
    assign row_prev = (row_x == '0) ? RW'(GRID_ROWS - 1) : row_x - RW'(1);
    assign row_next = (row_x + RW'(1) >= RW'(GRID_ROWS)) ? '0 : row_x + RW'(1);
    assign col_prev = (col_x == '0) ? CW'(GRID_COLS - 1) : col_x - CW'(1);
    assign col_next = (col_x + CW'(1) >= CW'(GRID_COLS)) ? '0 : col_x + CW'(1);

    assign in_grid = (row_x < RW'(GRID_ROWS)) && (col_x < CW'(GRID_COLS));
    assign in_band = (row_reg >= band_first_row) && ({1'b0, row_reg} < band_end_row);

    always_comb begin
        case (cmd.step) inside
            [4'd0:4'd2]: row_sel = row_prev;
            [4'd3:4'd5]: row_sel = row_x;
            [4'd6:4'd8]: row_sel = row_next;
            default:     row_sel = row_x;
        endcase
        case (cmd.step) inside
            4'd0, 4'd3, 4'd6: col_sel = col_prev;
            4'd2, 4'd5, 4'd8: col_sel = col_next;
            default:          col_sel = col_x;
        endcase
    end

    assign addr_calc = AW'(row_sel) * AW'(GRID_COLS) + AW'(col_sel);

    always_ff @(posedge aclk) begin
        if (cmd.addr) begin
            addr_reg <= addr_calc;
        end
        addr_self_reg <= (cmd.step == lcns_pkg::STEP_CENTER);
        rd_self_reg   <= addr_self_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_vld_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            addr_vld_reg <= cmd.addr & cmd.read;
            rd_vld_reg   <= addr_vld_reg;
        end
    end

    lcns_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (cmd.write),
        .addr  (addr_reg),
        .wdata (value_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (rd_vld_reg && !rd_self_reg && ram_rdata) begin
            count_reg <= count_reg + lcns_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg && rd_self_reg) begin
            self_reg <= ram_rdata;
        end
    end

    assign life_bit = (count_reg == lcns_pkg::CNT_BIRTH) ||
                      ((count_reg == lcns_pkg::CNT_SURVIVE) && self_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_oob_reg   <= cmd.oob;
            out_state_reg <= cmd.oob ? 1'b0 : life_bit;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_next_state  = out_state_reg;
    assign m_out_of_band = out_oob_reg;

    assign status.query    = (mode_reg == lcns_pkg::MODE_QUERY);
    assign status.oob      = !(in_grid && in_band);
    assign status.write_ok = in_grid;
    assign status.busy     = addr_vld_reg | rd_vld_reg;
    assign status.out_free = !out_valid_reg || m_ready;

    `LCNS_ASSERT_NOW(a_write_alone, cmd.write, !addr_vld_reg && !rd_vld_reg,
        "grid write overlaps a neighbor read")
    `LCNS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= lcns_pkg::CNT_MAX,
        "neighbor count exceeds eight")
    `LCNS_ASSERT_NEXT(a_emit_shows, cmd.emit, m_valid,
        "result not presented after emit")

endmodule

@@ rtl/lcns_ctrl.sv @@
// Controller FSM: sequences cell writes and the nine-cell neighborhood read.
// Depends on lcns_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "life_cell_next_state_top_macros.svh"

module lcns_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lcns_pkg::lcns_status_t status,
    output lcns_pkg::lcns_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECIDE = 6'b000010,
        ST_WRITE  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [lcns_pkg::STEP_W-1:0] step_reg;
    logic [lcns_pkg::STEP_W-1:0] step_next;
    logic                        oob_reg;
    logic                        oob_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        oob_next   = oob_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!status.query) begin
                    cmd.addr   = 1'b1;
                    cmd.step   = lcns_pkg::STEP_CENTER;
                    state_next = ST_WRITE;
                end else if (status.oob) begin
                    oob_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.clear  = 1'b1;
                    oob_next   = 1'b0;
                    step_next  = lcns_pkg::STEP_FIRST;
                    state_next = ST_READ;
                end
            end
            ST_WRITE: begin
                cmd.write  = status.write_ok;
                state_next = ST_IDLE;
            end
            ST_READ: begin
                cmd.addr = 1'b1;
                cmd.read = 1'b1;
                if (step_reg == lcns_pkg::STEP_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    step_next = step_reg + lcns_pkg::STEP_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.oob    = oob_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= lcns_pkg::STEP_FIRST;
            oob_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            oob_reg   <= oob_next;
        end
    end

    `LCNS_ASSERT_NOW(a_emit_drained, state_reg == ST_EMIT, !status.busy,
        "result emitted with reads in flight")
    `LCNS_ASSERT_NEXT(a_read_ends, (state_reg == ST_READ) && (step_reg == lcns_pkg::STEP_LAST),
        state_reg == ST_DRAIN, "read sequence did not end after ninth cell")
    `LCNS_ASSERT_NOW(a_idle_quiet, s_ready, !status.busy,
        "request taken while reads in flight")

endmodule

@@ rtl/life_cell_next_state_top.sv @@
// Top level of the Life cell next-state block: APB band registers, controller, datapath.
// Depends on lcns_pkg, lcns_ctrl and lcns_datapath.
//
//   channel   direction  handshake        payload
//   s_        in         s_valid/s_ready  s_mode, s_row, s_col, s_cell_value
//   m_        out        m_valid/m_ready  m_next_state, m_out_of_band
//   apb       in         psel/penable     paddr, pwdata -> prdata
//
// Write request: accept, decode, then the grid write, after which s_ready returns.
// Query in band: accept, decode, nine reads of the single-port grid RAM, a drain
// behind its two-stage read pipeline, and the result.
// Query out of band: accept, decode, and the result.
// Reset is synchronous on aresetn low; grid contents are not cleared.
// A finished result waits in the output register while m_ready is low; the
// next request is taken meanwhile and only stalls at its own result.
`timescale 1ns / 1ps

module life_cell_next_state_top #(
    parameter int GRID_ROWS = lcns_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lcns_pkg::GRID_COLS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [lcns_pkg::ROW_W-1:0]  s_row,
    input  logic [lcns_pkg::COL_W-1:0]  s_col,
    input  logic                        s_cell_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_next_state,
    output logic                        m_out_of_band,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcns_pkg::APB_AW-1:0] paddr,
    input  logic [lcns_pkg::APB_DW-1:0] pwdata,
    output logic [lcns_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    logic [lcns_pkg::FIRST_W-1:0] band_first_reg;
    logic [lcns_pkg::END_W-1:0]   band_end_reg;
    logic                         cfg_write;
    lcns_pkg::lcns_cmd_t          cmd;
    lcns_pkg::lcns_status_t       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_first_reg <= lcns_pkg::FIRST_RST;
            band_end_reg   <= lcns_pkg::END_RST;
        end else if (cfg_write) begin
            if (paddr[2] == lcns_pkg::REG_FIRST) begin
                band_first_reg <= pwdata[lcns_pkg::FIRST_W-1:0];
            end else begin
                band_end_reg <= pwdata[lcns_pkg::END_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == lcns_pkg::REG_END) ?
                    lcns_pkg::APB_DW'(band_end_reg) : lcns_pkg::APB_DW'(band_first_reg);

    lcns_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lcns_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_mode         (s_mode),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_cell_value   (s_cell_value),
        .band_first_row (band_first_reg),
        .band_end_row   (band_end_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_state   (m_next_state),
        .m_out_of_band  (m_out_of_band)
    );

endmodule
